// ===== src/msar_pkg.sv =====
// ----------------------------------------------------------------------------
// msar_pkg: shared types and codes for the MIPS subset ALU / register file
// Opcode and funct codes, register file geometry, and the result struct.
// ----------------------------------------------------------------------------
package msar_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW    = 5;
  localparam int DATA_W    = 32;

  // opcodes, instruction bits 31..26
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;

  // funct codes, instruction bits 5..0
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;

  typedef struct packed {
    logic              wrote;
    logic              unsup;
    logic [REG_AW-1:0] idx;
    logic [DATA_W-1:0] val;
  } res_t;

endpackage

// ===== src/msar_ram.sv =====
// ----------------------------------------------------------------------------
// msar_ram: generic single-write, single-read synchronous RAM
// Read data is registered and only updates when the read enable is high.
// ----------------------------------------------------------------------------
module msar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mips_subset_alu_regfile.sv =====
// ----------------------------------------------------------------------------
// mips_subset_alu_regfile: execute stage for a MIPS32 ALU subset
// Decodes R-type and I-type words, runs add/sub/and/or and their immediate
// forms on a 32 x 32-bit register file, and reports each register write.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+----------------------
//  in_     | in  | instruction_word[31:0]         | -
//  out_    | out | dest_index[4:0], dest_value    | wrote, unsupported
//
//  One item per cycle while the output is not stalled; the stages are register
//  file read, then execute and writeback into the output register.
//  The register file sits in two RAM copies, one per source operand; a
//  result written at the same edge as the next read is forwarded.
//  Reset clears per-register valid bits, so every register reads zero.
//  A stalled output holds the execute stage and the RAM read data; input
//  is still taken while the output register is full and being drained.
//
module mips_subset_alu_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] instruction_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] dest_index, [36:5] dest_value, zero pad
  output logic [1:0]  out_tuser   // [0] wrote, [1] unsupported
);

  localparam int AW = msar_pkg::REG_AW;
  localparam int DW = msar_pkg::DATA_W;

  logic                  in_fire;
  logic                  s1_adv;
  logic                  out_free;

  logic                  s1_valid_r;
  logic [31:0]           s1_instr_r;

  logic                  fwd_en_r;
  logic [AW-1:0]         fwd_idx_r;
  logic [DW-1:0]         fwd_data_r;

  logic [msar_pkg::REG_COUNT-1:0] valid_r;

  logic                  out_valid_r;
  msar_pkg::res_t        out_r;
  msar_pkg::res_t        res;

  logic [DW-1:0]         rd_a;
  logic [DW-1:0]         rd_b;
  logic [DW-1:0]         op_a;
  logic [DW-1:0]         op_b;

  logic [5:0]            s1_opc;
  logic [5:0]            s1_fn;
  logic [AW-1:0]         s1_rs;
  logic [AW-1:0]         s1_rt;
  logic [AW-1:0]         s1_rd;
  logic [15:0]           s1_imm;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_opc = s1_instr_r[31:26];
  assign s1_rs  = s1_instr_r[25:21];
  assign s1_rt  = s1_instr_r[20:16];
  assign s1_rd  = s1_instr_r[15:11];
  assign s1_fn  = s1_instr_r[5:0];
  assign s1_imm = s1_instr_r[15:0];

  msar_ram #(
    .WIDTH(DW),
    .DEPTH(msar_pkg::REG_COUNT)
  ) u_ram_a (
    .clk  (clk),
    .we   (s1_adv && res.wrote),
    .waddr(res.idx),
    .wdata(res.val),
    .re   (in_fire),
    .raddr(in_tdata[25:21]),
    .rdata(rd_a)
  );

  msar_ram #(
    .WIDTH(DW),
    .DEPTH(msar_pkg::REG_COUNT)
  ) u_ram_b (
    .clk  (clk),
    .we   (s1_adv && res.wrote),
    .waddr(res.idx),
    .wdata(res.val),
    .re   (in_fire),
    .raddr(in_tdata[20:16]),
    .rdata(rd_b)
  );

  // operand select: same-edge write wins, else RAM data if ever written
  always_comb begin
    if (fwd_en_r && (fwd_idx_r == s1_rs)) begin
      op_a = fwd_data_r;
    end else if (valid_r[s1_rs]) begin
      op_a = rd_a;
    end else begin
      op_a = '0;
    end
    if (fwd_en_r && (fwd_idx_r == s1_rt)) begin
      op_b = fwd_data_r;
    end else if (valid_r[s1_rt]) begin
      op_b = rd_b;
    end else begin
      op_b = '0;
    end
  end

  always_comb begin
    res.wrote = 1'b1;
    res.unsup = 1'b0;
    res.idx   = s1_rt;
    res.val   = '0;
    if (s1_opc == msar_pkg::OP_RTYPE) begin
      res.idx = s1_rd;
      unique case (s1_fn) inside
        msar_pkg::FN_ADD, msar_pkg::FN_ADDU: res.val = op_a + op_b;
        msar_pkg::FN_SUB, msar_pkg::FN_SUBU: res.val = op_a - op_b;
        msar_pkg::FN_AND:                    res.val = op_a & op_b;
        msar_pkg::FN_OR:                     res.val = op_a | op_b;
        default: begin
          res.wrote = 1'b0;
          res.unsup = 1'b1;
          res.idx   = '0;
        end
      endcase
    end else begin
      unique case (s1_opc) inside
        msar_pkg::OP_ADDI, msar_pkg::OP_ADDIU: begin
          res.val = op_a + {{(DW-16){s1_imm[15]}}, s1_imm};
        end
        msar_pkg::OP_ANDI: res.val = op_a & {{(DW-16){1'b0}}, s1_imm};
        msar_pkg::OP_ORI:  res.val = op_a | {{(DW-16){1'b0}}, s1_imm};
        default: begin
          res.wrote = 1'b0;
          res.unsup = 1'b1;
          res.idx   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_en_r    <= 1'b0;
      valid_r     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // capture the write that lands on the same edge as this read
      if (in_fire) begin
        fwd_en_r <= s1_adv && res.wrote;
      end
      if (s1_adv && res.wrote) begin
        valid_r[res.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_tdata;
      fwd_idx_r  <= res.idx;
      fwd_data_r <= res.val;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.val, out_r.idx};
  assign out_tuser  = {out_r.unsup, out_r.wrote};

endmodule
